// ===== src/stq_pkg.sv =====
// shared types, constants and codes for the sorted task list queue
// no dependencies
package stq_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int HANDLE_W    = 4;
  localparam int KEY_W       = 32;
  localparam int LINK_W      = $clog2(MAX_ENTRIES + 1);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [LINK_W-1:0]   link_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [KEY_W-1:0]    key_t;

  // link value of the sentinel slot, head and tail of the list
  localparam link_t SENT = link_t'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_REMOVE = 3'd2,
    FN_POP    = 3'd3,
    FN_PEEK   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_PRESENT = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WALK   = 5'b00010,
    S_LINK_A = 5'b00100,
    S_LINK_B = 5'b01000,
    S_UNLINK = 5'b10000
  } state_t;

  typedef struct packed {
    handle_t raddr;
    logic    key_we;
    handle_t key_waddr;
    key_t    key_wdata;
    logic    next_we;
    handle_t next_waddr;
    link_t   next_wdata;
    logic    prev_we;
    handle_t prev_waddr;
    link_t   prev_wdata;
  } mem_req_t;

  typedef struct packed {
    key_t  key;
    link_t next_link;
    link_t prev_link;
  } mem_rsp_t;

  typedef struct packed {
    status_t status;
    logic    valid;
    handle_t handle;
    count_t  count;
  } res_t;

endpackage

// ===== src/stq_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/stq_ctrl.sv =====
// sequencer of the sorted task list queue: list walk, relink, head/tail,
// listed flags, count and result register; depends on stq_pkg
module stq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        func,
  input  stq_pkg::handle_t  item_handle,
  input  stq_pkg::key_t     key,
  output logic              busy,
  output stq_pkg::mem_req_t req,
  input  stq_pkg::mem_rsp_t rsp,
  output logic              done,
  output stq_pkg::res_t     res
);

  stq_pkg::state_t  state;
  stq_pkg::func_t   fn_q;
  stq_pkg::handle_t h_q;
  stq_pkg::key_t    key_q;
  stq_pkg::link_t   cur;
  stq_pkg::link_t   at_q;
  stq_pkg::link_t   p_q;
  stq_pkg::link_t   head;
  stq_pkg::link_t   tail;
  stq_pkg::count_t  count;
  logic [stq_pkg::MAX_ENTRIES-1:0] listed;

  assign busy = (state != stq_pkg::S_IDLE);

  // ram requests
  always_comb begin
    req = '0;
    req.raddr = h_q;
    case (state)
      stq_pkg::S_IDLE: begin
        req.raddr = (func == stq_pkg::FN_REMOVE) ? item_handle
                                                 : head[stq_pkg::HANDLE_W-1:0];
      end
      stq_pkg::S_WALK: begin
        req.raddr = rsp.next_link[stq_pkg::HANDLE_W-1:0];
      end
      stq_pkg::S_LINK_A: begin
        req.key_we     = 1'b1;
        req.key_waddr  = h_q;
        req.key_wdata  = key_q;
        req.next_we    = 1'b1;
        req.next_waddr = h_q;
        req.next_wdata = at_q;
        req.prev_we    = 1'b1;
        req.prev_waddr = h_q;
        req.prev_wdata = p_q;
      end
      stq_pkg::S_LINK_B: begin
        req.next_we    = (p_q != stq_pkg::SENT);
        req.next_waddr = p_q[stq_pkg::HANDLE_W-1:0];
        req.next_wdata = stq_pkg::link_t'(h_q);
        req.prev_we    = (at_q != stq_pkg::SENT);
        req.prev_waddr = at_q[stq_pkg::HANDLE_W-1:0];
        req.prev_wdata = stq_pkg::link_t'(h_q);
      end
      stq_pkg::S_UNLINK: begin
        req.next_we    = (rsp.prev_link != stq_pkg::SENT);
        req.next_waddr = rsp.prev_link[stq_pkg::HANDLE_W-1:0];
        req.next_wdata = rsp.next_link;
        req.prev_we    = (rsp.next_link != stq_pkg::SENT);
        req.prev_waddr = rsp.next_link[stq_pkg::HANDLE_W-1:0];
        req.prev_wdata = rsp.prev_link;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= stq_pkg::S_IDLE;
      head   <= stq_pkg::SENT;
      tail   <= stq_pkg::SENT;
      count  <= '0;
      listed <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        stq_pkg::S_IDLE: begin
          if (start) begin
            fn_q       <= stq_pkg::func_t'(func);
            h_q        <= item_handle;
            key_q      <= key;
            cur        <= head;
            res.valid  <= 1'b0;
            res.handle <= '0;
            res.count  <= count;
            res.status <= stq_pkg::ST_OK;
            case (func)
              stq_pkg::FN_APPEND, stq_pkg::FN_INSERT: begin
                if (listed[item_handle]) begin
                  res.status <= stq_pkg::ST_PRESENT;
                  done       <= 1'b1;
                end else if (func == stq_pkg::FN_APPEND || head == stq_pkg::SENT) begin
                  at_q  <= stq_pkg::SENT;
                  p_q   <= tail;
                  state <= stq_pkg::S_LINK_A;
                end else begin
                  state <= stq_pkg::S_WALK;
                end
              end
              stq_pkg::FN_REMOVE: begin
                if (count == '0) begin
                  res.status <= stq_pkg::ST_EMPTY;
                  done       <= 1'b1;
                end else if (!listed[item_handle]) begin
                  res.status <= stq_pkg::ST_ABSENT;
                  done       <= 1'b1;
                end else begin
                  state <= stq_pkg::S_UNLINK;
                end
              end
              stq_pkg::FN_POP: begin
                if (count == '0) begin
                  res.status <= stq_pkg::ST_EMPTY;
                  done       <= 1'b1;
                end else begin
                  h_q   <= head[stq_pkg::HANDLE_W-1:0];
                  state <= stq_pkg::S_UNLINK;
                end
              end
              stq_pkg::FN_PEEK: begin
                if (count == '0) begin
                  res.status <= stq_pkg::ST_EMPTY;
                end else begin
                  res.valid  <= 1'b1;
                  res.handle <= head[stq_pkg::HANDLE_W-1:0];
                end
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        stq_pkg::S_WALK: begin
          // rsp holds the entry at cur
          if (rsp.key <= key_q) begin
            if (rsp.next_link == stq_pkg::SENT) begin
              at_q  <= stq_pkg::SENT;
              p_q   <= tail;
              state <= stq_pkg::S_LINK_A;
            end else begin
              cur <= rsp.next_link;
            end
          end else begin
            at_q  <= cur;
            p_q   <= rsp.prev_link;
            state <= stq_pkg::S_LINK_A;
          end
        end
        stq_pkg::S_LINK_A: begin
          state <= stq_pkg::S_LINK_B;
        end
        stq_pkg::S_LINK_B: begin
          if (p_q == stq_pkg::SENT) begin
            head <= stq_pkg::link_t'(h_q);
          end
          if (at_q == stq_pkg::SENT) begin
            tail <= stq_pkg::link_t'(h_q);
          end
          listed[h_q] <= 1'b1;
          count       <= stq_pkg::count_t'(count + 1'b1);
          res.status  <= stq_pkg::ST_OK;
          res.valid   <= 1'b0;
          res.handle  <= '0;
          res.count   <= stq_pkg::count_t'(count + 1'b1);
          done        <= 1'b1;
          state       <= stq_pkg::S_IDLE;
        end
        stq_pkg::S_UNLINK: begin
          if (rsp.prev_link == stq_pkg::SENT) begin
            head <= rsp.next_link;
          end
          if (rsp.next_link == stq_pkg::SENT) begin
            tail <= rsp.prev_link;
          end
          listed[h_q] <= 1'b0;
          count       <= stq_pkg::count_t'(count - 1'b1);
          res.status  <= stq_pkg::ST_OK;
          res.valid   <= (fn_q == stq_pkg::FN_POP);
          res.handle  <= (fn_q == stq_pkg::FN_POP) ? h_q : '0;
          res.count   <= stq_pkg::count_t'(count - 1'b1);
          done        <= 1'b1;
          state       <= stq_pkg::S_IDLE;
        end
        default: begin
          state <= stq_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/sorted_task_list_queue.sv =====
// top level of the sorted task list queue: sequencer plus key and link rams
// depends on stq_pkg, stq_ram, stq_ctrl
//
// usage
//   a command transfer happens at a clock edge with start high and busy low;
//   func, item_handle and key are sampled there. busy stays low for
//   commands answered at once and high while a list walk or relink runs.
//   each command gives exactly one result, shown for one cycle with done
//   high: status, result_valid, result_handle, entry_count, is_empty.
//   the receiver cannot stall; done is not held.
// command sequence
//   peek, unused codes and rejected commands: result in the cycle after the
//   transfer, next command accepted in the very next cycle.
//   append and insert into an empty list: link_a then link_b. remove and pop: unlink.
//   sorted insert into a non-empty list first walks the list, comparing the
//   key with each entry read from the key/link rams in turn, then passes
//   through link_a and link_b.
// reset
//   synchronous rst empties the list: head and tail point to the sentinel,
//   all listed flags and the count clear. ram contents need no clearing.
module sorted_task_list_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [3:0]  item_handle,
  input  logic [31:0] key,
  output logic        done,
  output logic [1:0]  status,
  output logic        result_valid,
  output logic [3:0]  result_handle,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  stq_pkg::mem_req_t req;
  stq_pkg::mem_rsp_t rsp;
  stq_pkg::res_t     res;

  stq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .item_handle (item_handle),
    .key         (key),
    .busy        (busy),
    .req         (req),
    .rsp         (rsp),
    .done        (done),
    .res         (res)
  );

  stq_ram #(
    .WIDTH (stq_pkg::KEY_W),
    .DEPTH (stq_pkg::MAX_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (req.key_we),
    .waddr (req.key_waddr),
    .wdata (req.key_wdata),
    .raddr (req.raddr),
    .rdata (rsp.key)
  );

  stq_ram #(
    .WIDTH (stq_pkg::LINK_W),
    .DEPTH (stq_pkg::MAX_ENTRIES)
  ) u_next_ram (
    .clk   (clk),
    .we    (req.next_we),
    .waddr (req.next_waddr),
    .wdata (req.next_wdata),
    .raddr (req.raddr),
    .rdata (rsp.next_link)
  );

  stq_ram #(
    .WIDTH (stq_pkg::LINK_W),
    .DEPTH (stq_pkg::MAX_ENTRIES)
  ) u_prev_ram (
    .clk   (clk),
    .we    (req.prev_we),
    .waddr (req.prev_waddr),
    .wdata (req.prev_wdata),
    .raddr (req.raddr),
    .rdata (rsp.prev_link)
  );

  assign status        = res.status;
  assign result_valid  = res.valid;
  assign result_handle = res.handle;
  assign entry_count   = res.count;
  assign is_empty      = (res.count == '0);

endmodule

// ===== bench/tb.sv =====
// self-checking bench for sorted_task_list_queue: directed then random commands,
// every answer compared against a tracked copy of the list held in a small class
// depends on stq_pkg and the sorted_task_list_queue rtl
`timescale 1ns / 100ps

module tb;
  import stq_pkg::*;

  localparam int HEAD = MAX_ENTRIES;

  typedef struct {
    status_t status;
    logic    valid;
    handle_t handle;
    count_t  count;
    logic    empty;
  } answer_t;

  class list_tracker;
    key_t    key_mem[MAX_ENTRIES];
    int      nxt[MAX_ENTRIES+1];
    int      prv[MAX_ENTRIES+1];
    bit      on_list[MAX_ENTRIES];
    int      count;
    answer_t answers_due[$];
    int      errors;

    function new();
      foreach (on_list[i]) on_list[i] = 1'b0;
      foreach (key_mem[i]) key_mem[i] = '0;
      foreach (nxt[i]) begin
        nxt[i] = 0;
        prv[i] = 0;
      end
      nxt[HEAD] = HEAD;
      prv[HEAD] = HEAD;
      count = 0;
      errors = 0;
    endfunction

    function void link_in(int h, int at);
      int p;
      p = prv[at];
      nxt[h] = at;
      prv[h] = p;
      nxt[p] = h;
      prv[at] = h;
      on_list[h] = 1'b1;
      count++;
    endfunction

    function void unlink(int h);
      int p;
      int n;
      p = prv[h];
      n = nxt[h];
      nxt[p] = n;
      prv[n] = p;
      on_list[h] = 1'b0;
      count--;
    endfunction

    // update the tracked list for one accepted command, queue the answer it gives
    function void record_command(logic [2:0] f, handle_t h, key_t k);
      answer_t a;
      int at;
      int front;
      a.status = ST_OK;
      a.valid = 1'b0;
      a.handle = '0;
      case (f)
        FN_APPEND, FN_INSERT: begin
          if (on_list[h]) begin
            a.status = ST_PRESENT;
          end else begin
            at = HEAD;
            if (f == FN_INSERT) begin
              at = nxt[HEAD];
              while (at != HEAD && key_mem[at] <= k) at = nxt[at];
            end
            key_mem[h] = k;
            link_in(int'(h), at);
          end
        end
        FN_REMOVE: begin
          if (count == 0) a.status = ST_EMPTY;
          else if (!on_list[h]) a.status = ST_ABSENT;
          else unlink(int'(h));
        end
        FN_POP, FN_PEEK: begin
          if (count == 0) begin
            a.status = ST_EMPTY;
          end else begin
            front = nxt[HEAD];
            a.valid = 1'b1;
            a.handle = handle_t'(front);
            if (f == FN_POP) unlink(front);
          end
        end
        default: ;
      endcase
      a.count = count_t'(count);
      a.empty = (count == 0);
      answers_due.push_back(a);
    endfunction

    function void check_answer(logic [1:0] st, logic v, logic [3:0] rh, logic [4:0] cnt,
                               logic emp);
      answer_t a;
      if (answers_due.size() == 0) begin
        $error("answer with no command waiting");
        errors++;
        return;
      end
      a = answers_due.pop_front();
      if (st !== a.status) begin
        $error("status: expected %0d, got %0d", a.status, st);
        errors++;
      end
      if (v !== a.valid) begin
        $error("result_valid: expected %0d, got %0d", a.valid, v);
        errors++;
      end
      if (rh !== a.handle) begin
        $error("result_handle: expected %0d, got %0d", a.handle, rh);
        errors++;
      end
      if (cnt !== a.count) begin
        $error("entry_count: expected %0d, got %0d", a.count, cnt);
        errors++;
      end
      if (emp !== a.empty) begin
        $error("is_empty: expected %0d, got %0d", a.empty, emp);
        errors++;
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // random handle that is (or is not) on the list, any handle if none fits
    function handle_t pick(bit want_listed);
      handle_t cands[$];
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (on_list[i] == want_listed) cands.push_back(handle_t'(i));
      if (cands.size() == 0) return handle_t'($urandom_range(0, MAX_ENTRIES - 1));
      return cands[$urandom_range(0, cands.size() - 1)];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func = '0;
  logic [3:0]  item_handle = '0;
  logic [31:0] key = '0;
  logic        done;
  logic [1:0]  status;
  logic        result_valid;
  logic [3:0]  result_handle;
  logic [4:0]  entry_count;
  logic        is_empty;

  list_tracker sb = new();

  sorted_task_list_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .item_handle  (item_handle),
    .key          (key),
    .done         (done),
    .status       (status),
    .result_valid (result_valid),
    .result_handle(result_handle),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_answer(status, result_valid, result_handle, entry_count, is_empty);
  end

  // present one command and hold it until the transfer
  task automatic send(input logic [2:0] f, input handle_t h, input key_t k);
    start <= 1'b1;
    func <= f;
    item_handle <= h;
    key <= k;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.record_command(f, h, k);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic key_t rand_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return key_t'($urandom_range(0, 7));
      4:          return $urandom_range(0, 1) ? '1 : '0;
      default:    return key_t'($urandom);
    endcase
  endfunction

  initial begin
    int         r;
    bit         filling;
    logic [2:0] f;
    handle_t    h;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, unused codes, duplicates, absent handles, key extremes
    send(FN_PEEK, 4'd0, '0);
    send(FN_POP, 4'd0, '0);
    idle(1);
    send(FN_REMOVE, 4'd3, '0);
    send(3'd5, 4'd15, '1);
    send(3'd6, 4'd0, '0);
    idle(2);
    send(3'd7, 4'd15, '1);
    send(FN_APPEND, 4'd0, '0);
    send(FN_INSERT, 4'd15, '1);
    idle(1);
    send(FN_INSERT, 4'd1, '0);
    send(FN_INSERT, 4'd2, 32'h8000_0000);
    send(FN_APPEND, 4'd0, 32'd5);
    send(FN_INSERT, 4'd15, '0);
    idle(3);
    send(FN_REMOVE, 4'd7, '0);
    send(FN_PEEK, 4'd0, '0);
    send(FN_REMOVE, 4'd1, '0);
    send(FN_REMOVE, 4'd15, '0);
    send(FN_POP, 4'd0, '0);
    send(FN_INSERT, 4'd3, '0);
    idle(1);
    send(FN_INSERT, 4'd4, '1);
    send(FN_PEEK, 4'd0, '0);
    send(FN_POP, 4'd0, '0);
    send(FN_POP, 4'd0, '0);
    send(FN_POP, 4'd0, '0);
    send(FN_POP, 4'd0, '0);
    send(FN_INSERT, 4'd9, 32'd1);

    for (int i = 0; i < 1800; i++) begin
      filling = ((i / 100) % 2) == 0;
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 40) f = FN_INSERT;
        else if (r < 65) f = FN_APPEND;
        else if (r < 75) f = FN_REMOVE;
        else if (r < 85) f = FN_POP;
        else if (r < 97) f = FN_PEEK;
        else f = 3'($urandom_range(5, 7));
      end else begin
        if (r < 15) f = FN_INSERT;
        else if (r < 25) f = FN_APPEND;
        else if (r < 55) f = FN_REMOVE;
        else if (r < 85) f = FN_POP;
        else if (r < 97) f = FN_PEEK;
        else f = 3'($urandom_range(5, 7));
      end
      if (f == FN_APPEND || f == FN_INSERT)
        h = ($urandom_range(0, 99) < 85) ? sb.pick(1'b0) : handle_t'($urandom_range(0, 15));
      else if (f == FN_REMOVE)
        h = ($urandom_range(0, 99) < 80) ? sb.pick(1'b1) : handle_t'($urandom_range(0, 15));
      else
        h = handle_t'($urandom_range(0, 15));
      send(f, h, rand_key());
      if (i == 900) begin
        drain();
        repeat (5) @(posedge clk);
      end else if (((i / 150) % 3) != 1) begin
        idle(rand_gap());
      end
    end

    drain();
    repeat (25) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** sorted_task_list_queue: PASSED **");
    end else begin
      $display("** sorted_task_list_queue: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** sorted_task_list_queue: FAILED **");
    $finish;
  end

endmodule
